/* hdl/pssd_pkg.sv */
// Shared types and constants for the point-to-segment squared distance block.
`timescale 1ns / 1ps
package pssd_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int OUT_W       = 2 * COORD_WIDTH + 2;
    localparam int DIV_STEPS   = OUT_W;
    localparam int NUM_W       = 2 * OUT_W;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [OUT_W-1:0]       t_dist;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_pssd_in;

    typedef struct packed {
        t_dist sq_distance;
    } t_pssd_out;

    // Travels beside the quotient: the value to report and whether to subtract it.
    typedef struct packed {
        t_dist base;
        logic  proj;
    } t_pssd_side;
endpackage

/* hdl/pssd_in_if.sv */
// Input channel carrying one point and one segment per transaction.
`timescale 1ns / 1ps
interface pssd_in_if;
    import pssd_pkg::*;
    logic     valid;
    logic     ready;
    t_pssd_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pssd_out_if.sv */
// Output channel carrying one squared distance per transaction.
`timescale 1ns / 1ps
interface pssd_out_if;
    import pssd_pkg::*;
    logic      valid;
    logic      ready;
    t_pssd_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pssd_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module pssd_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [pssd_pkg::NUM_W-1:0] i_num,
    input  pssd_pkg::t_dist       i_den,
    input  pssd_pkg::t_pssd_side  i_side,
    output logic                  o_vld,
    output pssd_pkg::t_dist       o_quot,
    output pssd_pkg::t_pssd_side  o_side
);
    import pssd_pkg::*;

    logic       r_vld  [DIV_STEPS];
    t_dist      r_rem  [DIV_STEPS];
    t_dist      r_low  [DIV_STEPS];
    t_dist      r_quot [DIV_STEPS];
    t_dist      r_den  [DIV_STEPS];
    t_pssd_side r_side [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic       p_vld;
            t_dist      p_rem;
            t_dist      p_low;
            t_dist      p_quot;
            t_dist      p_den;
            t_pssd_side p_side;
            logic [OUT_W:0] trial;
            logic       ge;

            if (k == 0) begin : g_first
                // The quotient fits in OUT_W bits, so the top half is already below the divisor.
                assign p_vld  = i_vld;
                assign p_rem  = i_num[NUM_W-1:OUT_W];
                assign p_low  = i_num[OUT_W-1:0];
                assign p_quot = '0;
                assign p_den  = i_den;
                assign p_side = i_side;
            end else begin : g_rest
                assign p_vld  = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_low  = r_low[k-1];
                assign p_quot = r_quot[k-1];
                assign p_den  = r_den[k-1];
                assign p_side = r_side[k-1];
            end

            assign trial = {p_rem, p_low[OUT_W-1]};
            assign ge    = (trial >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? OUT_W'(trial - {1'b0, p_den}) : OUT_W'(trial);
                    r_low[k]  <= {p_low[OUT_W-2:0], 1'b0};
                    r_quot[k] <= {p_quot[OUT_W-2:0], ge};
                    r_den[k]  <= p_den;
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quot = r_quot[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];
endmodule

/* hdl/point_segment_sq_distance.sv */
// Top level of the point-to-segment squared distance pipeline.
`timescale 1ns / 1ps
// This block takes a query point C and segment endpoints A and B in signed Q8.8 and
// returns the squared distance from C to the segment in unsigned Q18.16. It accepts
// one transaction per clock unless the output stalls, and delivers one result per
// transaction, in order. One stage forms the coordinate differences, one the
// products, one the dot products, one selects the case and squares the projection,
// 34 stages of a restoring divider each produce one quotient bit, and the last stage
// subtracts and holds the result. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall on the output side freezes
// every stage and nothing is lost or repeated. When the projection is not positive
// the result is |AC|^2, when it reaches |AB|^2 the result is |BC|^2, and otherwise it
// is |AC|^2 minus the truncated quotient of the squared projection by |AB|^2.
module point_segment_sq_distance (
    input  logic i_clk,
    input  logic i_rst_n,
    pssd_in_if.sink    i_in,
    pssd_out_if.source o_out
);
    import pssd_pkg::*;

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: coordinate differences.
    logic  r1_vld;
    t_diff r1_ab [3];
    t_diff r1_ac [3];
    t_diff r1_bc [3];
    t_coord c_pt [3];
    t_coord c_st [3];
    t_coord c_en [3];

    assign c_pt[0] = i_in.data.point_x;
    assign c_pt[1] = i_in.data.point_y;
    assign c_pt[2] = i_in.data.point_z;
    assign c_st[0] = i_in.data.start_x;
    assign c_st[1] = i_in.data.start_y;
    assign c_st[2] = i_in.data.start_z;
    assign c_en[0] = i_in.data.end_x;
    assign c_en[1] = i_in.data.end_y;
    assign c_en[2] = i_in.data.end_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= DIFF_W'(c_en[k]) - DIFF_W'(c_st[k]);
                r1_ac[k] <= DIFF_W'(c_pt[k]) - DIFF_W'(c_st[k]);
                r1_bc[k] <= DIFF_W'(c_pt[k]) - DIFF_W'(c_en[k]);
            end
        end
    end

    // Stage 2: the twelve component products.
    logic  r2_vld;
    t_prod r2_pe [3];
    t_prod r2_pf [3];
    t_prod r2_pa [3];
    t_prod r2_pb [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_pe[k] <= PROD_W'(r1_ac[k]) * PROD_W'(r1_ab[k]);
                r2_pf[k] <= PROD_W'(r1_ab[k]) * PROD_W'(r1_ab[k]);
                r2_pa[k] <= PROD_W'(r1_ac[k]) * PROD_W'(r1_ac[k]);
                r2_pb[k] <= PROD_W'(r1_bc[k]) * PROD_W'(r1_bc[k]);
            end
        end
    end

    // Stage 3: dot products. The squared lengths are non-negative and fit OUT_W bits.
    logic  r3_vld;
    t_sum  r3_e;
    t_sum  r3_f;
    t_dist r3_acsq;
    t_dist r3_bcsq;
    t_sum  n3_acsq;
    t_sum  n3_bcsq;

    assign n3_acsq = SUM_W'(r2_pa[0]) + SUM_W'(r2_pa[1]) + SUM_W'(r2_pa[2]);
    assign n3_bcsq = SUM_W'(r2_pb[0]) + SUM_W'(r2_pb[1]) + SUM_W'(r2_pb[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_e    <= SUM_W'(r2_pe[0]) + SUM_W'(r2_pe[1]) + SUM_W'(r2_pe[2]);
            r3_f    <= SUM_W'(r2_pf[0]) + SUM_W'(r2_pf[1]) + SUM_W'(r2_pf[2]);
            r3_acsq <= n3_acsq[OUT_W-1:0];
            r3_bcsq <= n3_bcsq[OUT_W-1:0];
        end
    end

    // Stage 4: pick the case and square the projection for the divider.
    logic       r4_vld;
    logic [NUM_W-1:0] r4_e2;
    t_dist      r4_f;
    t_pssd_side r4_side;
    logic       n4_le0;
    logic       n4_gef;
    t_dist      n4_e;

    assign n4_le0 = (r3_e <= 0);
    assign n4_gef = (r3_e >= r3_f);
    // Only in the projection case is e used, and there 0 < e < f < 2^OUT_W.
    assign n4_e   = r3_e[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_e2 <= NUM_W'(n4_e) * NUM_W'(n4_e);
            r4_f  <= r3_f[OUT_W-1:0];
            if (n4_le0) begin
                r4_side <= '{base: r3_acsq, proj: 1'b0};
            end else if (n4_gef) begin
                r4_side <= '{base: r3_bcsq, proj: 1'b0};
            end else begin
                r4_side <= '{base: r3_acsq, proj: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // Divider stages. When the case is not a projection the quotient is ignored, so a
    // zero divisor there does no harm.
    logic       d_vld;
    t_dist      d_quot;
    t_pssd_side d_side;

    pssd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_num   (r4_e2),
        .i_den   (r4_f),
        .i_side  (r4_side),
        .o_vld   (d_vld),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    // Output stage: the quotient never exceeds |AC|^2, so the difference stays non-negative.
    logic  r_out_vld;
    t_dist r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_dist <= d_side.proj ? (d_side.base - d_quot) : d_side.base;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.data.sq_distance = r_out_dist;
endmodule
